@@ hdl/ut2cal_pkg.sv @@
package ut2cal_pkg;

  localparam int unsigned NUM_STAGES = 15;
  localparam int unsigned STAGE_W    = 4;

  localparam logic signed [16:0] OFFSET_RESET = 17'sd28800;

  // configuration register indexes
  localparam logic CFG_OFFSET = 1'b0;
  localparam logic CFG_DST_EN = 1'b1;

  // stage codes: UTC date path, then local date path
  localparam logic [STAGE_W-1:0] ST_UMUL   = 4'd0;
  localparam logic [STAGE_W-1:0] ST_USPLIT = 4'd1;
  localparam logic [STAGE_W-1:0] ST_UERA   = 4'd2;
  localparam logic [STAGE_W-1:0] ST_UCENT  = 4'd3;
  localparam logic [STAGE_W-1:0] ST_UQ4    = 4'd4;
  localparam logic [STAGE_W-1:0] ST_UYOE   = 4'd5;
  localparam logic [STAGE_W-1:0] ST_UYMD   = 4'd6;
  localparam logic [STAGE_W-1:0] ST_DST    = 4'd7;
  localparam logic [STAGE_W-1:0] ST_LMUL   = 4'd8;
  localparam logic [STAGE_W-1:0] ST_LSPLIT = 4'd9;
  localparam logic [STAGE_W-1:0] ST_LERA   = 4'd10;
  localparam logic [STAGE_W-1:0] ST_LCENT  = 4'd11;
  localparam logic [STAGE_W-1:0] ST_LQ4    = 4'd12;
  localparam logic [STAGE_W-1:0] ST_LYOE   = 4'd13;
  localparam logic [STAGE_W-1:0] ST_LYMD   = 4'd14;

  // reciprocals: floor(x/d) == (x*M) >> k over the ranges used here
  localparam logic [27:0] RECIP_675  = 28'd203613265;  // k = 37, x < 2^27
  localparam logic [16:0] RECIP_1461 = 17'd91868;      // k = 27, x < 2^16
  localparam logic [12:0] RECIP_60S  = 13'd4370;       // k = 18, x < 3600
  localparam logic [22:0] RECIP_60L  = 23'd4473925;    // k = 28, x < 2^22

  typedef struct packed {
    logic [32:0] utc;
    logic [33:0] x;      // second count, shifted by one day on the local path, never negative
    logic [17:0] q;      // day count of x
    logic [16:0] sod;
    logic [19:0] z;      // days since 0000-03-01
    logic        era5;
    logic [17:0] doe;
    logic [2:0]  wd;
    logic [1:0]  c;
    logic [15:0] doc;
    logic [4:0]  q4;
    logic [8:0]  yoe;
    logic [8:0]  doy;
    logic [11:0] yr;
    logic [3:0]  mo;
    logic [4:0]  dy;
    logic        dst;
    logic [4:0]  hr;
    logic [11:0] rem;
    logic [5:0]  mn;
    logic [5:0]  sc;
    logic [21:0] jdn;
    logic [16:0] idxq;
    logic [5:0]  idx;
    logic [3:0]  branch;
    logic [3:0]  stem;
  } pipe_t;

  function automatic logic [17:0] div_day(input logic [33:0] x);
    logic [54:0] p;
    p = 55'(x[33:7]) * 55'(RECIP_675);
    return p[54:37];
  endfunction

  function automatic logic [2:0] mod7(input logic [20:0] v);
    logic [5:0] s;
    logic [3:0] f;
    s = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
      + 6'(v[17:15]) + 6'(v[20:18]);
    f = 4'(s[5:3]) + 4'(s[2:0]);
    if (f >= 4'd7) f = f - 4'd7;
    return f[2:0];
  endfunction

  // first day of each March-based month
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic pipe_t step_split(input pipe_t p, input logic [19:0] base);
    pipe_t n;
    n = p;
    n.sod = 17'(p.x - 34'(p.q) * 34'd86400);
    n.z   = 20'(p.q) + base;
    return n;
  endfunction

  function automatic pipe_t step_era(input pipe_t p);
    pipe_t n;
    n = p;
    n.era5 = (p.z >= 20'd730485);
    n.doe  = 18'(p.z - (n.era5 ? 20'd730485 : 20'd584388));
    n.wd   = mod7(21'(p.z) + 21'd3);
    return n;
  endfunction

  function automatic pipe_t step_cent(input pipe_t p);
    pipe_t n;
    n = p;
    if (p.doe >= 18'd109572)     n.c = 2'd3;
    else if (p.doe >= 18'd73048) n.c = 2'd2;
    else if (p.doe >= 18'd36524) n.c = 2'd1;
    else                         n.c = 2'd0;
    n.doc = 16'(p.doe - 18'(n.c) * 18'd36524);
    return n;
  endfunction

  function automatic pipe_t step_q4(input pipe_t p);
    pipe_t n;
    logic [32:0] m;
    n = p;
    m = 33'(p.doc) * 33'(RECIP_1461);
    n.q4 = m[31:27];
    return n;
  endfunction

  function automatic pipe_t step_yoe(input pipe_t p);
    pipe_t n;
    logic [10:0] dq;
    logic [1:0]  y1;
    n = p;
    dq = 11'(p.doc - 16'(p.q4) * 16'd1461);
    if (dq >= 11'd1095)     y1 = 2'd3;
    else if (dq >= 11'd730) y1 = 2'd2;
    else if (dq >= 11'd365) y1 = 2'd1;
    else                    y1 = 2'd0;
    n.doy = 9'(dq - 11'(y1) * 11'd365);
    n.yoe = 9'(p.c) * 9'd100 + 9'(p.q4) * 9'd4 + 9'(y1);
    return n;
  endfunction

  function automatic pipe_t step_ymd(input pipe_t p);
    pipe_t n;
    logic [3:0] mp;
    n = p;
    mp = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (p.doy >= month_start(4'(i))) mp = 4'(i);
    end
    n.dy = 5'(p.doy - month_start(mp) + 9'd1);
    n.mo = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
    n.yr = 12'(p.yoe) + (p.era5 ? 12'd2000 : 12'd1600) + ((n.mo <= 4'd2) ? 12'd1 : 12'd0);
    return n;
  endfunction

  // EU rule on the UTC date: switch on the last Sunday at 01:00 UTC
  function automatic pipe_t step_dst(input pipe_t p, input logic signed [16:0] ofs,
                                     input logic st_en);
    pipe_t n;
    logic        past;
    logic [35:0] s;
    n = p;
    past = ((6'(p.dy) + 6'd7 - 6'(p.wd)) >= 6'd32) &&
           ((p.wd != 3'd0) || (p.sod >= 17'd3600));
    n.dst = st_en && (((p.mo >= 4'd4) && (p.mo <= 4'd9)) ||
                      ((p.mo == 4'd3) && past) || ((p.mo == 4'd10) && !past));
    s = {3'b000, p.utc} + {{19{ofs[16]}}, ofs} + (n.dst ? 36'd3600 : 36'd0) + 36'd86400;
    n.x = s[33:0];
    return n;
  endfunction

  function automatic pipe_t pipe_step(input logic [STAGE_W-1:0] k, input pipe_t p,
                                      input logic signed [16:0] ofs, input logic st_en);
    pipe_t       n;
    logic [21:0] y;
    logic [44:0] m45;
    logic [24:0] m25;
    logic [3:0]  b;
    logic [5:0]  r5;
    logic [4:0]  t;
    n = p;
    y = p.jdn + 22'd49;
    case (k)
      ST_UMUL, ST_LMUL: n.q = div_day(p.x);
      ST_USPLIT: n = step_split(p, 20'd719468);
      ST_LSPLIT: n = step_split(p, 20'd719467);  // x carries one extra day
      ST_UERA:   n = step_era(p);
      ST_UCENT:  n = step_cent(p);
      ST_UQ4:    n = step_q4(p);
      ST_UYOE:   n = step_yoe(p);
      ST_UYMD, ST_LYMD: n = step_ymd(p);
      ST_DST:    n = step_dst(p, ofs, st_en);
      ST_LERA: begin
        n = step_era(p);
        n.hr = 5'd0;
        for (int i = 1; i < 24; i++) begin
          if (p.sod >= 17'(i * 3600)) n.hr = 5'(i);
        end
        n.jdn = 22'(p.z) + 22'd1721120;
      end
      ST_LCENT: begin
        n = step_cent(p);
        n.rem = 12'(p.sod - 17'(p.hr) * 17'd3600);
        m45 = 45'(y) * 45'(RECIP_60L);
        n.idxq = m45[44:28];
      end
      ST_LQ4: begin
        n = step_q4(p);
        m25 = 25'(p.rem) * 25'(RECIP_60S);
        n.mn = m25[23:18];
        n.idx = 6'(y - 22'(p.idxq) * 22'd60);
      end
      ST_LYOE: begin
        n = step_yoe(p);
        n.sc = 6'(p.rem - 12'(p.mn) * 12'd60);
        b = 4'((5'(p.hr) + 5'd1) >> 1);
        if (b == 4'd12) b = 4'd0;
        n.branch = b;
        r5 = 6'(p.idx - 6'((11'(p.idx) * 11'd13) >> 6) * 6'd5);
        t = 5'(r5) * 5'd2 + 5'(b);
        if (t >= 5'd10) t = t - 5'd10;
        n.stem = t[3:0];
      end
      default: n = p;
    endcase
    return n;
  endfunction

endpackage

@@ hdl/unix_time_to_calendar_sexagenary.sv @@
// One item per cycle while the output is not stalled.
// Fifteen register stages: the UTC date (for the summer-time rule), then the
// local date; each stage holds until the one after it has room.
// Reset (rst_ni low, asynchronous): pipeline empty, offset 28800 s,
// summer time off.
module unix_time_to_calendar_sexagenary (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [32:0] unix_utc_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_of_month_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o,
  output logic [2:0]  weekday_o,
  output logic [21:0] julian_day_number_o,
  output logic [5:0]  day_cycle_index_o,
  output logic [3:0]  hour_stem_o,
  output logic [3:0]  hour_branch_o,
  output logic        summer_time_active_o
);

  localparam int unsigned N = ut2cal_pkg::NUM_STAGES;

  logic signed [16:0] offset_q;
  logic               dst_en_q;

  ut2cal_pkg::pipe_t entry;
  ut2cal_pkg::pipe_t stg_d [N];
  ut2cal_pkg::pipe_t stg_q [N];
  logic [N-1:0]      vld_q;
  logic [N:0]        rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= ut2cal_pkg::OFFSET_RESET;
      dst_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ut2cal_pkg::CFG_OFFSET: offset_q <= cfg_wdata_i;
        ut2cal_pkg::CFG_DST_EN: dst_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    entry     = '0;
    entry.utc = unix_utc_seconds_i;
    entry.x   = {1'b0, unix_utc_seconds_i};
  end

  assign rdy[N] = !out_stall_i;

  for (genvar s = 0; s < N; s++) begin : g_stage
    assign rdy[s] = !vld_q[s] || rdy[s+1];

    if (s == 0) begin : g_first
      assign stg_d[s] = ut2cal_pkg::pipe_step(ut2cal_pkg::STAGE_W'(s), entry,
                                              offset_q, dst_en_q);
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) vld_q[s] <= 1'b0;
        else if (rdy[s]) vld_q[s] <= in_valid_i;
      end
    end else begin : g_rest
      assign stg_d[s] = ut2cal_pkg::pipe_step(ut2cal_pkg::STAGE_W'(s), stg_q[s-1],
                                              offset_q, dst_en_q);
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) vld_q[s] <= 1'b0;
        else if (rdy[s]) vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) stg_q[s] <= stg_d[s];
    end
  end

  assign in_stall_o           = !rdy[0];
  assign out_valid_o          = vld_q[N-1];
  assign year_o               = stg_q[N-1].yr;
  assign month_o              = stg_q[N-1].mo;
  assign day_of_month_o       = stg_q[N-1].dy;
  assign hour_o               = stg_q[N-1].hr;
  assign minute_o             = stg_q[N-1].mn;
  assign second_o             = stg_q[N-1].sc;
  assign weekday_o            = stg_q[N-1].wd;
  assign julian_day_number_o  = stg_q[N-1].jdn;
  assign day_cycle_index_o    = stg_q[N-1].idx;
  assign hour_stem_o          = stg_q[N-1].stem;
  assign hour_branch_o        = stg_q[N-1].branch;
  assign summer_time_active_o = stg_q[N-1].dst;

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hour_o < 5'd24) && (minute_o < 6'd60) && (second_o < 6'd60))
    else $error("time of day out of range");

  a_cycle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (weekday_o < 3'd7) && (day_cycle_index_o < 6'd60) &&
                    (hour_branch_o < 4'd12) && (hour_stem_o < 4'd10))
    else $error("weekday or cycle index out of range");

  a_stem_parity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hour_stem_o[0] == hour_branch_o[0]))
    else $error("stem and branch parity differ");

endmodule

@@ sim/unix_time_to_calendar_sexagenary_tb.sv @@
`timescale 1ns / 100ps
module unix_time_to_calendar_sexagenary_tb;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  dom;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
    logic [21:0] jdn;
    logic [5:0]  cyc;
    logic [3:0]  stem;
    logic [3:0]  branch;
    logic        dst;
  } civil_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = ut2cal_pkg::CFG_OFFSET;
  logic [16:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [32:0] unix_utc_seconds_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  civil_t      got;

  unix_time_to_calendar_sexagenary DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .unix_utc_seconds_i,
    .out_valid_o, .out_stall_i,
    .year_o(got.year), .month_o(got.month), .day_of_month_o(got.dom),
    .hour_o(got.hour), .minute_o(got.minute), .second_o(got.second),
    .weekday_o(got.weekday), .julian_day_number_o(got.jdn),
    .day_cycle_index_o(got.cyc), .hour_stem_o(got.stem),
    .hour_branch_o(got.branch), .summer_time_active_o(got.dst)
  );

  civil_t      civil_q[$];
  longint      utc_offset = 28800;
  bit          summer_en = 1'b0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_recv = 1'b0;
  int          n_fail = 0;
  int          n_items = 0;
  int          n_checked = 0;
  int          n_summer = 0;
  longint      cycles = 0;

  initial forever #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if (a % b != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint epoch_days(longint y, longint m, longint d);
    longint yy, era, yoe, doy, doe;
    yy = (m <= 2) ? y - 1 : y;
    era = yy / 400;
    yoe = yy - era * 400;
    doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic void civil_from_days(input longint days, output longint y,
                                          output longint m, output longint d);
    longint z, era, doe, yoe, doy, mp;
    z = days + 719468;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    d = doy - (153 * mp + 2) / 5 + 1;
    m = mp < 10 ? mp + 3 : mp - 9;
    y = yoe + era * 400 + (m <= 2 ? 1 : 0);
  endfunction

  function automatic longint dow(longint days);
    return days + 4 - fdiv(days + 4, 7) * 7;
  endfunction

  // last Sunday of a 31-day month, 01:00 UTC
  function automatic longint eu_switch(longint y, longint m);
    longint last;
    last = epoch_days(y, m, 31);
    return (last - dow(last)) * 86400 + 3600;
  endfunction

  function automatic civil_t to_civil(logic [32:0] utc_in);
    civil_t r;
    longint utc, uy, um, ud, y, m, d, loc, days, sod, jdn, idx, hr, br;
    bit st;
    utc = longint'(utc_in);
    st = 1'b0;
    if (summer_en) begin
      civil_from_days(utc / 86400, uy, um, ud);
      st = utc >= eu_switch(uy, 3) && utc < eu_switch(uy, 10);
    end
    loc = utc + utc_offset + (st ? 3600 : 0);
    days = fdiv(loc, 86400);
    sod = loc - days * 86400;
    civil_from_days(days, y, m, d);
    jdn = days + 2440588;
    idx = (jdn + 49) % 60;
    hr = sod / 3600;
    br = ((hr + 1) / 2) % 12;
    r.year = y[11:0];
    r.month = m[3:0];
    r.dom = d[4:0];
    r.hour = hr[4:0];
    r.minute = 6'((sod / 60) % 60);
    r.second = 6'(sod % 60);
    r.weekday = 3'(dow(days));
    r.jdn = jdn[21:0];
    r.cyc = idx[5:0];
    r.stem = 4'(((idx % 5) * 2 + br) % 10);
    r.branch = br[3:0];
    r.dst = st;
    return r;
  endfunction

  // valid stays high after the accepting edge; the next send or drain decides
  task automatic send_time(input logic [32:0] t);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    unix_utc_seconds_i <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    civil_q.push_back(to_civil(t));
    n_items++;
    if (civil_q[$].dst) n_summer++;
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (civil_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [16:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ut2cal_pkg::CFG_OFFSET) utc_offset = longint'($signed(v));
    else summer_en = v[0];
  endtask

  always @(posedge clk_i) begin
    if (hold_recv) out_stall_i <= 1'b1;
    else out_stall_i <= recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct;
  end

  always @(posedge clk_i) begin
    civil_t exp_c;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (civil_q.size() == 0) begin
        $display("%0t unexpected result %p", $time, got);
        n_fail++;
      end else begin
        exp_c = civil_q.pop_front();
        n_checked++;
        if (got !== exp_c) begin
          $display("%0t mismatch expected %p actual %p", $time, exp_c, got);
          n_fail++;
        end
      end
    end
  end

  // random time; full range, near switch instants, near day edges or near the epoch
  function automatic logic [32:0] rand_time();
    longint y, base;
    case ($urandom_range(3))
      0: return {1'($urandom_range(1)), 32'($urandom())};
      1: begin
        y = $urandom_range(1970, 2241);
        base = eu_switch(y, $urandom_range(1) ? 3 : 10);
        return 33'(base + $urandom_range(14400) - 7200);
      end
      2: return 33'(longint'($urandom_range(99000)) * 86400 + $urandom_range(200) - 100 + 86400);
      default: return 33'($urandom_range(200000));
    endcase
  endfunction

  task automatic test_directed;
    logic [32:0] list[$];
    list = '{33'd0, 33'd1, 33'd86399, 33'd86400, 33'h1FFFFFFFF, 33'h100000000,
             33'h0FFFFFFFF, 33'd951782400, 33'd951868800, 33'd4107542400};
    foreach (list[i]) send_time(list[i]);
  endtask

  task automatic test_offsets;
    write_cfg(ut2cal_pkg::CFG_OFFSET, 17'(-50400));
    send_time(33'd0); send_time(33'd50399); send_time(33'h1FFFFFFFF);
    write_cfg(ut2cal_pkg::CFG_OFFSET, 17'h10000);
    send_time(33'd0); send_time(33'd65536);
    write_cfg(ut2cal_pkg::CFG_OFFSET, 17'h0FFFF);
    send_time(33'h1FFFFFFFF); send_time(33'd0);
    write_cfg(ut2cal_pkg::CFG_OFFSET, 17'd50400);
    send_time(33'd36000); send_time(33'h1FFFFFFFF);
  endtask

  task automatic test_summer_edges;
    longint s;
    write_cfg(ut2cal_pkg::CFG_DST_EN, 17'd1);
    write_cfg(ut2cal_pkg::CFG_OFFSET, 17'd3600);
    for (int y = 2020; y < 2022; y++) begin
      s = eu_switch(y, 3);
      send_time(33'(s - 1)); send_time(33'(s));
      s = eu_switch(y, 10);
      send_time(33'(s - 1)); send_time(33'(s));
    end
  endtask

  task automatic test_random(input int n);
    repeat (n) send_time(rand_time());
  endtask

  task automatic test_backpressure;
    fork
      begin
        hold_recv = 1'b1;
        repeat (60) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      test_random(40);
    join
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_offsets();
    test_summer_edges();
    send_idle_pct = 7; recv_idle_pct = 67;
    test_random(400);
    write_cfg(ut2cal_pkg::CFG_OFFSET, 17'(-3600));
    send_idle_pct = 67; recv_idle_pct = 7;
    test_random(400);
    write_cfg(ut2cal_pkg::CFG_DST_EN, 17'd0);
    write_cfg(ut2cal_pkg::CFG_OFFSET, 17'($urandom_range(100800) - 50400));
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(300);
    write_cfg(ut2cal_pkg::CFG_DST_EN, 17'd1);
    test_random(220);
    test_backpressure();
    drain();
    $display("Converted %0d times, %0d in summer time, over several offsets and stall mixes.",
             n_items, n_summer);
    if (n_fail == 0 && civil_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
